// ----- sv/rbv_pkg.sv -----
// Shared types, register indexes and reset values of the rigid body velocity step.
package rbv_pkg;

	localparam int RBV_WORD_BITS = 32;
	localparam int RBV_FRAC_BITS = 16;
	localparam int RBV_NUM_REGS  = 8;
	localparam int RBV_IDX_BITS  = $clog2(RBV_NUM_REGS);

	// Configuration register indexes
	localparam logic [RBV_IDX_BITS-1:0] REG_MASS     = 3'd0;
	localparam logic [RBV_IDX_BITS-1:0] REG_FRICTION = 3'd1;
	localparam logic [RBV_IDX_BITS-1:0] REG_FSCALE   = 3'd2;
	localparam logic [RBV_IDX_BITS-1:0] REG_HLIMIT   = 3'd3;
	localparam logic [RBV_IDX_BITS-1:0] REG_VLIMIT   = 3'd4;
	localparam logic [RBV_IDX_BITS-1:0] REG_GRAVITY  = 3'd5;
	localparam logic [RBV_IDX_BITS-1:0] REG_NORMAL_X = 3'd6;
	localparam logic [RBV_IDX_BITS-1:0] REG_NORMAL_Y = 3'd7;

	// Register reset values
	localparam longint RST_MASS     = 65536;
	localparam longint RST_FRICTION = 98304000;
	localparam longint RST_FSCALE   = 32768;
	localparam longint RST_HLIMIT   = 19660800;
	localparam longint RST_VLIMIT   = 52428800;
	localparam longint RST_GRAVITY  = 163840000;
	localparam longint RST_NORMAL_X = 65536;
	localparam longint RST_NORMAL_Y = 0;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} rbv_op_t;

	typedef struct packed {
		logic    start;
		rbv_op_t op;
	} rbv_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AX,
		ST_AY,
		ST_MX1,
		ST_MX2,
		ST_MY1,
		ST_MY2,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_KX,
		ST_DX,
		ST_KY,
		ST_DY,
		ST_GRAV,
		ST_CLAMP,
		ST_OX,
		ST_OY,
		ST_OUT
	} rbv_state_t;

endpackage

// ----- sv/rbv_if.sv -----
// Input and output channel interfaces of the rigid body velocity step.
interface rbv_in_if #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] force_x;
	logic signed [WORD_BITS-1:0] force_y;
	logic                        on_ground;
	logic [FRAC_BITS-1:0]        frame_time;

	modport source (output valid, force_x, force_y, on_ground, frame_time, input ready);
	modport sink (input valid, force_x, force_y, on_ground, frame_time, output ready);
endinterface

interface rbv_out_if #(
	parameter int WORD_BITS = 32
);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] velocity_x;
	logic signed [WORD_BITS-1:0] velocity_y;
	logic signed [WORD_BITS-1:0] move_x;
	logic signed [WORD_BITS-1:0] move_y;

	modport source (output valid, velocity_x, velocity_y, move_x, move_y, input ready);
	modport sink (input valid, velocity_x, velocity_y, move_x, move_y, output ready);
endinterface

// ----- sv/rbv_alu.sv -----
// Shared bit-serial unit: shift-add multiply, restoring divide and square root.
module rbv_alu import rbv_pkg::*; #(
	parameter int WORD_BITS = RBV_WORD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rbv_ctl_t                 ctl,
	input  logic [2*WORD_BITS-1:0]   opa,
	input  logic [WORD_BITS-1:0]     opb,
	output logic                     done,
	output logic [2*WORD_BITS-1:0]   res
);
	localparam int W  = WORD_BITS;
	localparam int DW = 2 * WORD_BITS;
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	rbv_op_t       op_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] x_q;
	logic [W-1:0]  y_q;
	logic [DW-1:0] acc_q;
	logic [W+1:0]  rem_q;

	logic [DW-1:0] x_d;
	logic [W-1:0]  y_d;
	logic [DW-1:0] acc_d;
	logic [W+1:0]  rem_d;
	logic [W:0]    div_r;
	logic [W+3:0]  sq_trial;
	logic [W+3:0]  sq_test;

	// One step of the selected operation
	always_comb begin
		x_d      = x_q;
		y_d      = y_q;
		acc_d    = acc_q;
		rem_d    = rem_q;
		div_r    = {rem_q[W-1:0], x_q[DW-1]};
		sq_trial = {rem_q, x_q[DW-1:DW-2]};
		sq_test  = {(W+2)'(acc_q[W-1:0]), 2'b01};
		case (op_q)
			OP_MUL: begin
				if (y_q[0]) begin
					acc_d = acc_q + x_q;
				end
				x_d = x_q << 1;
				y_d = y_q >> 1;
			end
			OP_DIV: begin
				x_d = x_q << 1;
				if (div_r >= {1'b0, y_q}) begin
					rem_d = (W+2)'(div_r - {1'b0, y_q});
					acc_d = {acc_q[DW-2:0], 1'b1};
				end else begin
					rem_d = (W+2)'(div_r);
					acc_d = {acc_q[DW-2:0], 1'b0};
				end
			end
			OP_SQRT: begin
				x_d = x_q << 2;
				if (sq_trial >= sq_test) begin
					rem_d = (W+2)'(sq_trial - sq_test);
					acc_d = {acc_q[DW-2:0], 1'b1};
				end else begin
					rem_d = (W+2)'(sq_trial);
					acc_d = {acc_q[DW-2:0], 1'b0};
				end
			end
			default: begin
				x_d = x_q;
			end
		endcase
	end

	// Control: load on start, count steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == OP_DIV) ? CW'(DW) : CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			x_q   <= opa;
			y_q   <= opb;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			x_q   <= x_d;
			y_q   <= y_d;
			acc_q <= acc_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

// ----- sv/rigid_body_velocity_step.sv -----
// Top level: one 2D rigid body frame step, sequenced over a shared serial unit.
//
// Channels: in_item carries force_x, force_y, on_ground and frame_time; out_item
// returns velocity_x, velocity_y, move_x and move_y, one result per item. Both
// use valid/ready; a transfer happens when both are high.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 mass,
// 1 friction, 2 start scale, 3/4 speed limits, 5 gravity, 6/7 normal).
// Write only while the block is idle.
// Sequence: each item runs through two divides (2*WORD_BITS steps each), two more
// divides for friction, fourteen multiplies (WORD_BITS steps each) and one square
// root (WORD_BITS steps) on the one shared unit, with a handoff between each
// operation and the next; fewer operations run on the ground or when friction
// stops the body.
// in_item.ready is high only while the block is idle.
// Reset clears velocity, the airborne flag and loads register defaults.
// A stalled receiver holds the result on out_item; no new item is taken until
// the result is gone.
module rigid_body_velocity_step import rbv_pkg::*; #(
	parameter int WORD_BITS = RBV_WORD_BITS,
	parameter int FRAC_BITS = RBV_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	rbv_in_if.sink                  in_item,
	rbv_out_if.source               out_item,
	input  logic                    cfg_we,
	input  logic [RBV_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]    cfg_data
);
	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int DW = 2 * WORD_BITS;
	localparam longint AIR_SCALE = ((longint'(1) << F) + 5) / 10;

	// Magnitude of a signed word
	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? W'(-v) : W'(v);
	endfunction

	// Saturate a magnitude to a signed word with the given sign
	function automatic logic signed [W-1:0] to_word(input logic [DW-1:0] m, input logic neg);
		logic [DW-1:0] cap;
		logic [DW-1:0] lim;
		cap = neg ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - DW'(1));
		lim = (m > cap) ? cap : m;
		to_word = neg ? -$signed(W'(lim)) : $signed(W'(lim));
	endfunction

	// Saturating signed add
	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_add = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			sat_add = s[W-1:0];
		end
	endfunction

	// Clamp magnitude with sign kept
	function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] v,
			input logic [W-2:0] lim);
		logic signed [W-1:0] l;
		l = $signed({1'b0, lim});
		if (mag(v) > {1'b0, lim}) begin
			clamp = v[W-1] ? -l : l;
		end else begin
			clamp = v;
		end
	endfunction

	// Configuration registers
	logic [W-2:0]        mass_q, fric_q, fscale_q, hlim_q, vlim_q, grav_q;
	logic signed [W-1:0] nx_q, ny_q;

	// Item and state registers
	rbv_state_t          state_q, state_d;
	logic signed [W-1:0] fx_q, fy_q;
	logic                gnd_q;
	logic [F-1:0]        dt_q;
	logic                air_q;
	logic signed [W-1:0] vx_q, vy_q, ax_q, ay_q, t_q, mx_q, my_q;
	logic [W-1:0]        fm_q, speed_q, keep_q;
	logic [DW-1:0]       sum_q;
	logic                issued_q;

	rbv_ctl_t            ctl;
	logic [DW-1:0]       opa;
	logic [W-1:0]        opb;
	logic                done;
	logic [DW-1:0]       res;
	logic [DW-1:0]       res_q;
	logic [W-1:0]        m_eff;
	logic [W-1:0]        dt_w;
	logic [W-1:0]        scale;
	logic                op_state;
	logic                in_acc;

	assign m_eff  = (mass_q == '0) ? W'(1) : {1'b0, mass_q};
	assign dt_w   = W'(dt_q);
	assign scale  = air_q ? W'(AIR_SCALE) : {1'b0, fscale_q};
	assign res_q  = res >> F;
	assign in_acc = in_item.valid && in_item.ready;

	rbv_alu #(.WORD_BITS(W)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opa    (opa),
		.opb    (opb),
		.done   (done),
		.res    (res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_d = ST_AX;
			ST_AX:    if (done) state_d = ST_AY;
			ST_AY:    if (done) state_d = ST_MX1;
			ST_MX1:   if (done) state_d = ST_MX2;
			ST_MX2:   if (done) state_d = ST_MY1;
			ST_MY1:   if (done) state_d = ST_MY2;
			ST_MY2:   if (done) state_d = ST_F1;
			ST_F1:    if (done) state_d = ST_F2;
			ST_F2:    if (done) state_d = ST_F3;
			ST_F3:    if (done) state_d = ST_SQX;
			ST_SQX:   if (done) state_d = ST_SQY;
			ST_SQY:   if (done) state_d = ST_SQRT;
			ST_SQRT: begin
				if (done) begin
					state_d = (res[W-1:0] <= fm_q) ? ST_GRAV : ST_KX;
				end
			end
			ST_KX:    if (done) state_d = ST_DX;
			ST_DX:    if (done) state_d = ST_KY;
			ST_KY:    if (done) state_d = ST_DY;
			ST_DY:    if (done) state_d = ST_GRAV;
			ST_GRAV:  if (gnd_q || done) state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_OX;
			ST_OX:    if (done) state_d = ST_OY;
			ST_OY:    if (done) state_d = ST_OUT;
			ST_OUT:   if (out_item.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Operation and operands for each state
	always_comb begin
		op_state = 1'b1;
		ctl.op   = OP_MUL;
		opa      = '0;
		opb      = '0;
		case (state_q)
			ST_AX: begin
				ctl.op = OP_DIV;
				opa    = DW'(mag(fx_q)) << F;
				opb    = m_eff;
			end
			ST_AY: begin
				ctl.op = OP_DIV;
				opa    = DW'(mag(fy_q)) << F;
				opb    = m_eff;
			end
			ST_MX1: begin
				opa = DW'(mag(ax_q));
				opb = mag(nx_q);
			end
			ST_MY1: begin
				opa = DW'(mag(ay_q));
				opb = mag(ny_q);
			end
			ST_MX2, ST_MY2, ST_F3: begin
				opa = DW'(mag(t_q));
				opb = dt_w;
			end
			ST_F1: begin
				opa = DW'(fric_q);
				opb = scale;
			end
			ST_F2: begin
				opa = DW'(mag(t_q));
				opb = m_eff;
			end
			ST_SQX: begin
				opa = DW'(mag(vx_q));
				opb = mag(vx_q);
			end
			ST_SQY: begin
				opa = DW'(mag(vy_q));
				opb = mag(vy_q);
			end
			ST_SQRT: begin
				ctl.op = OP_SQRT;
				opa    = sum_q;
			end
			ST_KX: begin
				opa = DW'(mag(vx_q));
				opb = keep_q;
			end
			ST_KY: begin
				opa = DW'(mag(vy_q));
				opb = keep_q;
			end
			ST_DX, ST_DY: begin
				ctl.op = OP_DIV;
				opa    = sum_q;
				opb    = speed_q;
			end
			ST_GRAV: begin
				op_state = !gnd_q;
				opa      = DW'(grav_q);
				opb      = dt_w;
			end
			ST_OX: begin
				opa = DW'(mag(vx_q));
				opb = dt_w;
			end
			ST_OY: begin
				opa = DW'(mag(vy_q));
				opb = dt_w;
			end
			default: begin
				op_state = 1'b0;
			end
		endcase
		ctl.start = op_state && !issued_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			air_q    <= 1'b0;
			vx_q     <= '0;
			vy_q     <= '0;
			mass_q   <= (W-1)'(RST_MASS);
			fric_q   <= (W-1)'(RST_FRICTION);
			fscale_q <= (W-1)'(RST_FSCALE);
			hlim_q   <= (W-1)'(RST_HLIMIT);
			vlim_q   <= (W-1)'(RST_VLIMIT);
			grav_q   <= (W-1)'(RST_GRAVITY);
			nx_q     <= W'(RST_NORMAL_X);
			ny_q     <= W'(RST_NORMAL_Y);
		end else begin
			state_q <= state_d;
			if (done) begin
				issued_q <= 1'b0;
			end else if (ctl.start) begin
				issued_q <= 1'b1;
			end
			if (in_acc && !in_item.on_ground) begin
				air_q <= 1'b1;
			end

			// Write configuration
			if (cfg_we) begin
				case (cfg_index)
					REG_MASS:     mass_q   <= cfg_data[W-2:0];
					REG_FRICTION: fric_q   <= cfg_data[W-2:0];
					REG_FSCALE:   fscale_q <= cfg_data[W-2:0];
					REG_HLIMIT:   hlim_q   <= cfg_data[W-2:0];
					REG_VLIMIT:   vlim_q   <= cfg_data[W-2:0];
					REG_GRAVITY:  grav_q   <= cfg_data[W-2:0];
					REG_NORMAL_X: nx_q     <= $signed(cfg_data);
					REG_NORMAL_Y: ny_q     <= $signed(cfg_data);
					default:      nx_q     <= nx_q;
				endcase
			end

			// Velocity updates
			case (state_q)
				ST_MX2: if (done) vx_q <= sat_add(vx_q, to_word(res_q, t_q[W-1]));
				ST_MY2: if (done) vy_q <= sat_add(vy_q, to_word(res_q, t_q[W-1]));
				ST_SQRT: begin
					if (done && res[W-1:0] <= fm_q) begin
						vx_q <= '0;
						vy_q <= '0;
					end
				end
				ST_DX:   if (done) vx_q <= to_word(res, vx_q[W-1]);
				ST_DY:   if (done) vy_q <= to_word(res, vy_q[W-1]);
				ST_GRAV: if (done) vy_q <= sat_add(vy_q, -to_word(res_q, 1'b0));
				ST_CLAMP: begin
					vx_q <= clamp(vx_q, hlim_q);
					vy_q <= clamp(vy_q, vlim_q);
				end
				default: vx_q <= vx_q;
			endcase
		end
	end

	// Payload and intermediate registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fx_q  <= in_item.force_x;
			fy_q  <= in_item.force_y;
			gnd_q <= in_item.on_ground;
			dt_q  <= in_item.frame_time;
		end
		if (done) begin
			case (state_q)
				ST_AX:   ax_q <= to_word(res, fx_q[W-1]);
				ST_AY:   ay_q <= to_word(res, fy_q[W-1]);
				ST_MX1:  t_q <= to_word(res_q, ax_q[W-1] ^ nx_q[W-1]);
				ST_MY1:  t_q <= to_word(res_q, ay_q[W-1] ^ ny_q[W-1]);
				ST_F1:   t_q <= to_word(res_q, 1'b0);
				ST_F2:   t_q <= to_word(res_q, 1'b0);
				ST_F3:   fm_q <= W'(to_word(res_q, 1'b0));
				ST_SQX:  sum_q <= res;
				ST_SQY:  sum_q <= sum_q + res;
				ST_SQRT: begin
					speed_q <= res[W-1:0];
					keep_q  <= res[W-1:0] - fm_q;
				end
				ST_KX:   sum_q <= res;
				ST_KY:   sum_q <= res;
				ST_OX:   mx_q <= to_word(res_q, vx_q[W-1]);
				ST_OY:   my_q <= to_word(res_q, vy_q[W-1]);
				default: t_q <= t_q;
			endcase
		end
	end

	// Channel outputs
	assign in_item.ready       = (state_q == ST_IDLE);
	assign out_item.valid      = (state_q == ST_OUT);
	assign out_item.velocity_x = vx_q;
	assign out_item.velocity_y = vy_q;
	assign out_item.move_x     = mx_q;
	assign out_item.move_y     = my_q;

endmodule

// ----- sim/rigid_body_velocity_step_tb.sv -----
// Self-checking testbench for the rigid body velocity step block.
`timescale 1ns / 1ps

module rigid_body_velocity_step_tb;
	import rbv_pkg::*;

	localparam int  WB = RBV_WORD_BITS;
	localparam int  FB = RBV_FRAC_BITS;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam longint AIR_SCALE = ((64'sd1 << FB) + 5) / 10;
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  PHASES = 8;
	localparam int  ITEMS_PER_PHASE = 125;

	typedef logic [127:0] u128_t;

	typedef struct {
		logic [WB-1:0] velocity_x;
		logic [WB-1:0] velocity_y;
		logic [WB-1:0] move_x;
		logic [WB-1:0] move_y;
	} motion_t;

	typedef struct {
		longint fx;
		longint fy;
		bit     ground;
		longint dt;
		bit     known;
		motion_t res;
	} body_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RBV_IDX_BITS-1:0] cfg_index = '0;
	logic [WB-1:0] cfg_data = '0;

	rbv_in_if #(.WORD_BITS(WB), .FRAC_BITS(FB)) in_bus ();
	rbv_out_if #(.WORD_BITS(WB)) out_bus ();

	rigid_body_velocity_step #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_bus),
		.out_item(out_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Model state and register copy
	longint  body_vx, body_vy;
	bit      body_airborne;
	longint  body_reg [RBV_NUM_REGS];
	motion_t motion_q [$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      airborne_items = 0;
	int      cycles = 0;
	bit      calm = 1'b0;
	int      ready_hold = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, motion_q.size());
			$display("rigid_body_velocity_step_tb: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] mag64(longint a);
		return (a < 0) ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint to_word(logic [63:0] m, bit neg);
		logic [63:0] cap;
		cap = neg ? 64'd2147483648 : 64'd2147483647;
		if (m > cap) m = cap;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sat_word(longint x);
		return (x > WMAX) ? WMAX : ((x < WMIN) ? WMIN : x);
	endfunction

	function automatic longint qmul(longint a, longint b);
		u128_t p;
		logic [63:0] m;
		p = (u128_t'(mag64(a)) * u128_t'(mag64(b))) >> FB;
		m = (p[127:64] != 0) ? '1 : p[63:0];
		return to_word(m, (a < 0) != (b < 0));
	endfunction

	function automatic logic [63:0] qdiv(u128_t n, logic [63:0] d);
		u128_t q;
		q = n / u128_t'(d);
		return (q > u128_t'(64'd2147483648)) ? 64'd2147483648 : q[63:0];
	endfunction

	function automatic logic [63:0] root_floor(u128_t n);
		logic [63:0] r, c;
		r = 0;
		for (int b = WB; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (u128_t'(c) * u128_t'(c) <= n) r = c;
		end
		return r;
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (mag64(v) > 64'(lim)) return (v < 0) ? -lim : lim;
		return v;
	endfunction

	// Advance the body by one frame and return the new motion
	function automatic motion_t advance_body(longint fx, longint fy, bit ground, longint dt);
		motion_t r;
		longint m, ax, ay, scale, fric;
		logic [63:0] speed, keep;
		u128_t sum;
		m = (body_reg[REG_MASS] == 0) ? 1 : body_reg[REG_MASS];
		ax = to_word(qdiv(u128_t'(mag64(fx)) << FB, 64'(m)), fx < 0);
		ay = to_word(qdiv(u128_t'(mag64(fy)) << FB, 64'(m)), fy < 0);
		body_vx = sat_word(body_vx + qmul(qmul(ax, body_reg[REG_NORMAL_X]), dt));
		body_vy = sat_word(body_vy + qmul(qmul(ay, body_reg[REG_NORMAL_Y]), dt));
		if (!ground) body_airborne = 1'b1;
		scale = body_airborne ? AIR_SCALE : body_reg[REG_FSCALE];
		fric = qmul(qmul(qmul(body_reg[REG_FRICTION], scale), m), dt);
		sum = u128_t'(mag64(body_vx)) * u128_t'(mag64(body_vx))
			+ u128_t'(mag64(body_vy)) * u128_t'(mag64(body_vy));
		speed = root_floor(sum);
		// stop the body when friction eats the whole speed
		if (speed <= 64'(fric)) begin
			body_vx = 0;
			body_vy = 0;
		end else begin
			keep = speed - 64'(fric);
			body_vx = to_word(qdiv(u128_t'(mag64(body_vx)) * u128_t'(keep), speed), body_vx < 0);
			body_vy = to_word(qdiv(u128_t'(mag64(body_vy)) * u128_t'(keep), speed), body_vy < 0);
		end
		if (!ground) body_vy = sat_word(body_vy - qmul(body_reg[REG_GRAVITY], dt));
		body_vx = clamp_mag(body_vx, body_reg[REG_HLIMIT]);
		body_vy = clamp_mag(body_vy, body_reg[REG_VLIMIT]);
		r.velocity_x = WB'(body_vx);
		r.velocity_y = WB'(body_vy);
		r.move_x = WB'(qmul(body_vx, dt));
		r.move_y = WB'(qmul(body_vy, dt));
		return r;
	endfunction

	// Receiver stalls in bursts
	always @(negedge clk) begin
		if (!calm && ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_bus.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			ready_hold <= $urandom_range(0, 16);
			out_bus.ready <= 1'b0;
		end else begin
			out_bus.ready <= 1'b1;
		end
	end

	// Check each result against the oldest expected motion
	always @(posedge clk) begin
		motion_t e;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			results_seen++;
			if (motion_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				e = motion_q.pop_front();
				if (out_bus.velocity_x !== e.velocity_x || out_bus.velocity_y !== e.velocity_y
					|| out_bus.move_x !== e.move_x || out_bus.move_y !== e.move_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: exp v=(%h,%h) m=(%h,%h) got v=(%h,%h) m=(%h,%h)",
							results_seen, e.velocity_x, e.velocity_y, e.move_x, e.move_y,
							out_bus.velocity_x, out_bus.velocity_y, out_bus.move_x,
							out_bus.move_y);
				end
			end
		end
	end

	// Present one item, hold it until taken
	task automatic send_item(longint fx, longint fy, bit ground, longint dt, bit known,
			motion_t res);
		motion_t p;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.force_x <= WB'(fx);
		in_bus.force_y <= WB'(fy);
		in_bus.on_ground <= ground;
		in_bus.frame_time <= FB'(dt);
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
		p = advance_body(fx, fy, ground, dt);
		if (!ground) airborne_items++;
		motion_q.push_back(known ? res : p);
	endtask

	task automatic write_reg(logic [RBV_IDX_BITS-1:0] idx, longint value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= WB'(value);
		if (idx == REG_NORMAL_X || idx == REG_NORMAL_Y)
			body_reg[idx] = longint'($signed(WB'(value)));
		else
			body_reg[idx] = value & 64'h7fff_ffff;
	endtask

	// Drain outstanding results before touching registers
	task automatic wait_idle();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (motion_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic longint pick_reg(bit is_signed, longint rst, int mode);
		int sel;
		sel = (mode == 0) ? $urandom_range(0, 5) : mode;
		case (sel)
			1: return is_signed ? WMIN : 0;
			2: return WMAX;
			3, 4: return rst;
			default: return is_signed ? longint'($signed($urandom()))
				: longint'($urandom() & 32'h7fff_ffff);
		endcase
	endfunction

	task automatic load_regs(int mode);
		write_reg(REG_MASS, pick_reg(0, RST_MASS, mode));
		write_reg(REG_FRICTION, pick_reg(0, RST_FRICTION, mode));
		write_reg(REG_FSCALE, pick_reg(0, RST_FSCALE, mode));
		write_reg(REG_HLIMIT, pick_reg(0, RST_HLIMIT, mode));
		write_reg(REG_VLIMIT, pick_reg(0, RST_VLIMIT, mode));
		write_reg(REG_GRAVITY, pick_reg(0, RST_GRAVITY, mode));
		write_reg(REG_NORMAL_X, pick_reg(1, RST_NORMAL_X, mode));
		write_reg(REG_NORMAL_Y, pick_reg(1, RST_NORMAL_Y, mode));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic longint rand_force();
		if ($urandom_range(0, 1)) return longint'($urandom_range(0, 1 << 22)) - (1 << 21);
		return longint'($signed($urandom()));
	endfunction

	body_row_t rows [$];
	motion_t   zero_motion = '{default: '0};

	initial begin
		int mode;
		in_bus.valid = 1'b0;
		in_bus.force_x = '0;
		in_bus.force_y = '0;
		in_bus.on_ground = 1'b1;
		in_bus.frame_time = '0;
		out_bus.ready = 1'b0;
		body_vx = 0;
		body_vy = 0;
		body_airborne = 1'b0;
		body_reg[REG_MASS] = RST_MASS;
		body_reg[REG_FRICTION] = RST_FRICTION;
		body_reg[REG_FSCALE] = RST_FSCALE;
		body_reg[REG_HLIMIT] = RST_HLIMIT;
		body_reg[REG_VLIMIT] = RST_VLIMIT;
		body_reg[REG_GRAVITY] = RST_GRAVITY;
		body_reg[REG_NORMAL_X] = RST_NORMAL_X;
		body_reg[REG_NORMAL_Y] = RST_NORMAL_Y;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: ground first so the start scale is exercised
		rows = '{
			'{0, 0, 1, 0, 1, zero_motion},
			'{WMAX, WMIN, 1, 0, 1, zero_motion},
			'{65536, 0, 1, 1092, 0, zero_motion},
			'{WMAX, 0, 1, 65535, 0, zero_motion},
			'{WMIN, WMAX, 1, 65535, 0, zero_motion},
			'{0, 0, 1, 1092, 0, zero_motion},
			'{20000000, 5000000, 1, 1092, 0, zero_motion},
			'{-3000000, -1, 1, 300, 0, zero_motion},
			'{1, 1, 1, 1, 0, zero_motion},
			'{0, 0, 0, 1092, 0, zero_motion},
			'{WMAX, WMAX, 0, 65535, 0, zero_motion},
			'{WMIN, WMIN, 0, 65535, 0, zero_motion},
			'{0, 0, 0, 0, 0, zero_motion},
			'{-65536, 65536, 1, 2000, 0, zero_motion}
		};
		foreach (rows[i])
			send_item(rows[i].fx, rows[i].fy, rows[i].ground, rows[i].dt, rows[i].known,
				rows[i].res);

		// Random phases: extremes, then mixed settings, defaults with no idling last
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			mode = (ph == 0) ? 1 : (ph == 1) ? 2 : (ph == PHASES - 1) ? 3 : 0;
			if (ph == PHASES - 1) calm = 1'b1;
			load_regs(mode);
			repeat (ITEMS_PER_PHASE)
				send_item(rand_force(), rand_force(), $urandom_range(0, 3) != 0,
					$urandom_range(0, 4) < 3 ? $urandom_range(500, 2200)
					: $urandom_range(0, 65535), 0, zero_motion);
		end

		wait_idle();
		repeat (200) @(posedge clk);
		$display("covered %0d results, %0d airborne items, %0d register phases",
			results_seen, airborne_items, PHASES + 1);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("rigid_body_velocity_step_tb: PASS");
		else
			$display("rigid_body_velocity_step_tb: FAIL");
		$finish;
	end

endmodule
